[hdl/rc5pwd_pkg.sv]
// Shared types and constants for the RC5 pulse-width decoder.
// No dependencies; imported by every module of the block.
package rc5pwd_pkg;

	localparam int unsigned CfgIndexW = 2;
	localparam int unsigned CfgDataW  = 8;
	localparam int unsigned DurW      = 8;
	localparam int unsigned AddrW     = 5;
	localparam int unsigned CmdW      = 6;

	localparam logic [15:0] FRAME_MARKER = 16'h0005;

	localparam logic [7:0] SHORT_MIN_RST = 8'd9;
	localparam logic [7:0] SHORT_MAX_RST = 8'd20;
	localparam logic [7:0] LONG_MIN_RST  = 8'd21;
	localparam logic [7:0] LONG_MAX_RST  = 8'd34;

	typedef enum logic [CfgIndexW-1:0] {
		REG_SHORT_MIN = 2'd0,
		REG_SHORT_MAX = 2'd1,
		REG_LONG_MIN  = 2'd2,
		REG_LONG_MAX  = 2'd3
	} reg_index_t;

	typedef enum logic [1:0] {
		KIND_START    = 2'd0,
		KIND_INTERVAL = 2'd1,
		KIND_TIMEOUT  = 2'd2
	} kind_t;

	typedef struct packed {
		logic [DurW-1:0] short_min;
		logic [DurW-1:0] short_max;
		logic [DurW-1:0] long_min;
		logic [DurW-1:0] long_max;
	} window_t;

	typedef struct packed {
		logic            valid_res;
		logic [AddrW-1:0] address;
		logic [CmdW-1:0]  command;
		logic            toggle;
	} result_t;

endpackage

[hdl/rc5_pulse_width_decoder_core.sv]
// RC5 pulse-width decoder: takes one item per cycle (start, interval, timeout).
// An item is held in the input register and then decoded; a timeout writes the result register.
// A result is presented once its timeout has left the input register and the result register
// has taken it. The only stall source is the result register: the input stalls only while the
// input register holds an item and out_stall keeps a result waiting.
// Depends on rc5pwd_pkg, rc5pwd_cfg and rc5pwd_frame.
module rc5_pulse_width_decoder_core
	import rc5pwd_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 wr_en,
	input  logic [CfgIndexW-1:0] wr_index,
	input  logic [CfgDataW-1:0]  wr_data,
	input  logic                 in_valid,
	output logic                 in_stall,
	input  logic [1:0]           kind,
	input  logic [DurW-1:0]      duration,
	output logic                 out_valid,
	input  logic                 out_stall,
	output logic                 valid_res,
	output logic [AddrW-1:0]     address,
	output logic [CmdW-1:0]      command,
	output logic                 toggle
);

	window_t         window;
	logic            valid_s1;
	kind_t           kind_s1;
	logic [DurW-1:0] duration_s1;
	logic            advance;
	logic            res_fire;
	result_t         result;
	logic            out_valid_q;
	result_t         result_q;

	rc5pwd_cfg u_cfg (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (wr_en),
		.wr_index (wr_index),
		.wr_data  (wr_data),
		.window   (window)
	);

	// Stage 1 moves on whenever the result register can take a new value.
	assign advance  = !out_valid_q || !out_stall;
	assign in_stall = valid_s1 && !advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			kind_s1     <= kind_t'(kind);
			duration_s1 <= duration;
		end
	end

	rc5pwd_frame u_frame (
		.clk      (clk),
		.arst_n   (arst_n),
		.fire     (valid_s1 && advance),
		.kind     (kind_s1),
		.duration (duration_s1),
		.window   (window),
		.res_fire (res_fire),
		.result   (result)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (res_fire) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res_fire) result_q <= result;
	end

	assign out_valid = out_valid_q;
	assign valid_res = result_q.valid_res;
	assign address   = result_q.address;
	assign command   = result_q.command;
	assign toggle    = result_q.toggle;

endmodule

[hdl/rc5pwd_cfg.sv]
// Timing window registers of the RC5 pulse-width decoder.
// Depends on rc5pwd_pkg.
module rc5pwd_cfg
	import rc5pwd_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 wr_en,
	input  logic [CfgIndexW-1:0] wr_index,
	input  logic [CfgDataW-1:0]  wr_data,
	output window_t              window
);

	window_t window_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			window_q.short_min <= SHORT_MIN_RST;
			window_q.short_max <= SHORT_MAX_RST;
			window_q.long_min  <= LONG_MIN_RST;
			window_q.long_max  <= LONG_MAX_RST;
		end else if (wr_en) begin
			case (reg_index_t'(wr_index))
				REG_SHORT_MIN: window_q.short_min <= wr_data;
				REG_SHORT_MAX: window_q.short_max <= wr_data;
				REG_LONG_MIN:  window_q.long_min  <= wr_data;
				REG_LONG_MAX:  window_q.long_max  <= wr_data;
				default: ;
			endcase
		end
	end

	assign window = window_q;

endmodule

[hdl/rc5pwd_frame.sv]
// Frame state of the RC5 pulse-width decoder: interval classing, bit shifting
// and the timeout report. Depends on rc5pwd_pkg.
module rc5pwd_frame
	import rc5pwd_pkg::*;
(
	input  logic            clk,
	input  logic            arst_n,
	input  logic            fire,
	input  kind_t           kind,
	input  logic [DurW-1:0] duration,
	input  window_t         window,
	output logic            res_fire,
	output result_t         result
);

	logic [15:0] shift_q,   shift_d;
	logic        invalid_q, invalid_d;
	logic        last_q,    last_d;
	logic        skip_q,    skip_d;
	logic        half_q,    half_d;

	logic        keep_bit;
	logic        flip_bit;
	logic [15:0] pushed;

	// Two shorts keep the previous bit, one long inverts it.
	assign keep_bit = shift_q[0];
	assign flip_bit = ~shift_q[0];

	always_comb begin
		shift_d   = shift_q;
		invalid_d = invalid_q;
		last_d    = last_q;
		skip_d    = skip_q;
		half_d    = half_q;
		pushed    = shift_q;
		case (kind)
			KIND_START: begin
				shift_d   = FRAME_MARKER;
				invalid_d = 1'b0;
				last_d    = 1'b0;
				skip_d    = 1'b0;
				half_d    = 1'b0;
			end
			KIND_INTERVAL: begin
				if (!invalid_q) begin
					if (skip_q) begin
						skip_d = 1'b0;
					end else if (last_q) begin
						invalid_d = 1'b1;
					end else if (duration < window.short_min || duration > window.long_max) begin
						invalid_d = 1'b1;
					end else if (duration <= window.short_max) begin
						if (half_q) begin
							pushed  = {shift_q[14:0], keep_bit};
							shift_d = pushed;
							half_d  = 1'b0;
							if (pushed[15]) begin
								last_d = 1'b1;
								if (pushed[0]) skip_d = 1'b1;
							end
						end else begin
							half_d = 1'b1;
						end
					end else if (duration >= window.long_min) begin
						if (half_q) begin
							invalid_d = 1'b1;
						end else begin
							pushed  = {shift_q[14:0], flip_bit};
							shift_d = pushed;
							if (pushed[15]) begin
								last_d = 1'b1;
								if (pushed[0]) skip_d = 1'b1;
							end
						end
					end else begin
						invalid_d = 1'b1;
					end
				end
			end
			KIND_TIMEOUT: begin
				skip_d    = 1'b0;
				invalid_d = 1'b1;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			shift_q   <= FRAME_MARKER;
			invalid_q <= 1'b1;
			last_q    <= 1'b0;
			skip_q    <= 1'b0;
			half_q    <= 1'b0;
		end else if (fire) begin
			shift_q   <= shift_d;
			invalid_q <= invalid_d;
			last_q    <= last_d;
			skip_q    <= skip_d;
			half_q    <= half_d;
		end
	end

	logic frame_ok;
	assign frame_ok = !invalid_q && !skip_q && last_q;

	assign res_fire         = fire && (kind == KIND_TIMEOUT);
	assign result.valid_res = frame_ok;
	assign result.address   = frame_ok ? shift_q[10:6] : '0;
	assign result.command   = frame_ok ? shift_q[5:0]  : '0;
	assign result.toggle    = frame_ok ? shift_q[11]   : 1'b0;

endmodule

[test/rc5_pulse_width_decoder_core_tb.sv]
// Self-checking testbench for rc5_pulse_width_decoder_core: random RC5 frames under
// several window settings, random idling on both handshakes, results checked in order.
// Depends on rc5pwd_pkg and the decoder RTL only.
module rc5_pulse_width_decoder_core_tb
	import rc5pwd_pkg::*;
();

	timeunit 1ns;
	timeprecision 1ps;

	localparam logic [1:0] KIND_UNUSED = 2'd3;
	localparam int PER_PHASE  = 155;
	localparam int CALM_FROM  = 1400;
	localparam int LONG_HOLD  = 300;
	localparam int SETTLE     = 8;
	localparam int LIMIT      = 500000;

	// Tracks the frame state of the decoder and the reports due on each timeout.
	class rc5_frame_tracker;
		window_t win;
		logic [15:0] frame_bits;
		bit frame_dead;
		bit frame_done;
		bit drop_edge;
		bit half_seen;
		result_t reports_due[$];
		int mismatches;

		function new();
			win = {SHORT_MIN_RST, SHORT_MAX_RST, LONG_MIN_RST, LONG_MAX_RST};
			frame_bits = FRAME_MARKER;
			frame_dead = 1'b1;
			frame_done = 1'b0;
			drop_edge = 1'b0;
			half_seen = 1'b0;
			mismatches = 0;
		endfunction

		function void write_reg(reg_index_t idx, logic [7:0] v);
			case (idx)
				REG_SHORT_MIN: win.short_min = v;
				REG_SHORT_MAX: win.short_max = v;
				REG_LONG_MIN:  win.long_min = v;
				REG_LONG_MAX:  win.long_max = v;
				default: begin
				end
			endcase
		endfunction

		function void push_bit(bit keep);
			logic b;
			b = frame_bits[0] ^ !keep;
			frame_bits = {frame_bits[14:0], b};
			if (frame_bits[15]) begin
				frame_done = 1'b1;
				if (frame_bits[0])
					drop_edge = 1'b1;
			end
		endfunction

		function void take_item(logic [1:0] k, logic [7:0] d);
			result_t r;
			case (k)
				KIND_START: begin
					frame_bits = FRAME_MARKER;
					frame_dead = 1'b0;
					frame_done = 1'b0;
					drop_edge = 1'b0;
					half_seen = 1'b0;
				end
				KIND_INTERVAL: begin
					if (frame_dead) begin
					end else if (drop_edge) begin
						drop_edge = 1'b0;
					end else if (frame_done) begin
						frame_dead = 1'b1;
					end else if (d < win.short_min || d > win.long_max) begin
						frame_dead = 1'b1;
					end else if (d <= win.short_max) begin
						if (half_seen) begin
							push_bit(1'b1);
							half_seen = 1'b0;
						end else begin
							half_seen = 1'b1;
						end
					end else if (d >= win.long_min) begin
						if (half_seen)
							frame_dead = 1'b1;
						else
							push_bit(1'b0);
					end else begin
						frame_dead = 1'b1;
					end
				end
				KIND_TIMEOUT: begin
					r = '0;
					if (!frame_dead && !drop_edge && frame_done) begin
						r.valid_res = 1'b1;
						r.address = frame_bits[10:6];
						r.command = frame_bits[5:0];
						r.toggle = frame_bits[11];
					end
					reports_due.push_back(r);
					drop_edge = 1'b0;
					frame_dead = 1'b1;
				end
				default: begin
				end
			endcase
		endfunction

		function void note_mismatch(string msg);
			mismatches++;
			if (mismatches <= 10)
				$display("%0t: %s", $time, msg);
		endfunction

		function void check_report(logic v, logic [AddrW-1:0] a, logic [CmdW-1:0] c,
			logic t);
			result_t exp;
			if (reports_due.size() == 0) begin
				note_mismatch($sformatf({"unexpected result valid_res=%0b ",
					"address=%0d command=%0d toggle=%0b"}, v, a, c, t));
				return;
			end
			exp = reports_due.pop_front();
			if (exp.valid_res !== v || exp.address !== a || exp.command !== c ||
				exp.toggle !== t)
				note_mismatch($sformatf({"result mismatch: expected valid_res=%0b ",
					"address=%0d command=%0d toggle=%0b, got valid_res=%0b ",
					"address=%0d command=%0d toggle=%0b"},
					exp.valid_res, exp.address, exp.command, exp.toggle, v, a, c, t));
		endfunction

		function int pending();
			return reports_due.size();
		endfunction
	endclass

	logic                 clk;
	logic                 arst_n;
	logic                 wr_en;
	logic [CfgIndexW-1:0] wr_index;
	logic [CfgDataW-1:0]  wr_data;
	logic                 in_valid;
	logic                 in_stall;
	logic [1:0]           kind;
	logic [DurW-1:0]      duration;
	logic                 out_valid;
	logic                 out_stall;
	logic                 valid_res;
	logic [AddrW-1:0]     address;
	logic [CmdW-1:0]      command;
	logic                 toggle;

	rc5_frame_tracker sb = new();
	int n_items = 0;
	int cycles = 0;
	bit calm = 1'b0;
	bit long_hold_req = 1'b0;

	rc5_pulse_width_decoder_core u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.wr_en     (wr_en),
		.wr_index  (wr_index),
		.wr_data   (wr_data),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.kind      (kind),
		.duration  (duration),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.valid_res (valid_res),
		.address   (address),
		.command   (command),
		.toggle    (toggle)
	);

	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > LIMIT) begin
			$display("FAIL");
			$finish;
		end
	end

	always @(posedge clk) begin
		if (out_valid && !out_stall)
			sb.check_report(valid_res, address, command, toggle);
	end

	// Result side: short random stalls, plus one long hold on request.
	initial begin : result_side
		int hold;
		hold = 0;
		out_stall <= 1'b0;
		forever begin
			@(posedge clk);
			if (long_hold_req) begin
				long_hold_req = 1'b0;
				hold = LONG_HOLD;
			end else if (hold == 0 && !calm && $urandom_range(0, 9) == 0) begin
				hold = $urandom_range(17, 1);
			end
			if (hold > 0) begin
				out_stall <= 1'b1;
				hold--;
			end else begin
				out_stall <= 1'b0;
			end
		end
	end

	task automatic send_item(input logic [1:0] k, input logic [7:0] d);
		int gap;
		if (!calm && $urandom_range(0, 7) == 0) begin
			gap = $urandom_range(17, 1);
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		kind <= k;
		duration <= d;
		do @(posedge clk); while (in_stall);
		sb.take_item(k, d);
		if (k != KIND_UNUSED)
			n_items++;
		if (n_items >= CALM_FROM)
			calm = 1'b1;
	endtask

	// Drop valid and hold until every report has come back.
	task automatic settle();
		in_valid <= 1'b0;
		do @(posedge clk); while (sb.pending() != 0);
		repeat (SETTLE) @(posedge clk);
	endtask

	task automatic load_window(input window_t w);
		int i;
		for (i = 0; i < 4; i++) begin
			wr_en <= 1'b1;
			wr_index <= reg_index_t'(i);
			wr_data <= w[(3 - i) * 8 +: 8];
			@(posedge clk);
			sb.write_reg(reg_index_t'(i), w[(3 - i) * 8 +: 8]);
		end
		wr_en <= 1'b0;
	endtask

	function automatic logic [7:0] pick_short();
		int lo, hi;
		lo = sb.win.short_min;
		hi = sb.win.short_max;
		if (lo > hi)
			return 8'($urandom);
		return 8'($urandom_range(hi, lo));
	endfunction

	function automatic logic [7:0] pick_long();
		int lo, hi;
		lo = sb.win.long_min;
		hi = sb.win.long_max;
		if (lo <= sb.win.short_max)
			lo = sb.win.short_max + 1;
		if (lo > hi)
			return 8'($urandom);
		return 8'($urandom_range(hi, lo));
	endfunction

	function automatic window_t rand_window();
		int sm, sx, lm, lx;
		sm = $urandom_range(60, 1);
		sx = sm + $urandom_range(40, 0);
		lm = sx + 1 + $urandom_range(20, 0);
		lx = lm + $urandom_range(60, 0);
		return {8'(sm), 8'(sx), 8'(lm), 8'(lx)};
	endfunction

	// Replace the duration with garbage when this edge is the one to spoil.
	task automatic send_edge(input logic [7:0] d, input int spoil, inout int n);
		if (n == spoil)
			d = 8'($urandom);
		n++;
		send_item(KIND_INTERVAL, d);
	endtask

	// One frame: 13 bits after the marker, trailing edge on most odd commands, then timeout.
	task automatic send_frame(input bit broken);
		bit prev, b;
		int spoil, n, i;
		prev = 1'b1;
		n = 0;
		spoil = broken ? $urandom_range(26, 0) : -1;
		send_item(KIND_START, 8'($urandom));
		for (i = 0; i < 13; i++) begin
			b = $urandom_range(1, 0);
			if (b == prev) begin
				send_edge(pick_short(), spoil, n);
				send_edge(pick_short(), spoil, n);
			end else begin
				send_edge(pick_long(), spoil, n);
			end
			prev = b;
		end
		if (prev && $urandom_range(9, 0) != 0)
			send_edge(8'($urandom), spoil, n);
		if ($urandom_range(19, 0) == 0)
			send_edge(pick_short(), spoil, n);
		if (!(broken && $urandom_range(3, 0) == 0))
			send_item(KIND_TIMEOUT, 8'($urandom));
	endtask

	task automatic run_traffic(input int upto);
		int r, i, burst;
		logic [1:0] k;
		while (n_items < upto) begin
			r = $urandom_range(9, 0);
			if (r < 6) begin
				send_frame(1'b0);
			end else if (r < 8) begin
				send_frame(1'b1);
			end else begin
				burst = $urandom_range(4, 1);
				for (i = 0; i < burst; i++) begin
					k = 2'($urandom);
					send_item(k, 8'($urandom));
				end
			end
		end
	endtask

	initial begin : stimulus
		window_t plan[10];
		int ph;
		arst_n <= 1'b0;
		wr_en <= 1'b0;
		wr_index <= REG_SHORT_MIN;
		wr_data <= '0;
		in_valid <= 1'b0;
		kind <= KIND_START;
		duration <= '0;

		plan[0] = {SHORT_MIN_RST, SHORT_MAX_RST, LONG_MIN_RST, LONG_MAX_RST};
		plan[1] = {8'd0, 8'd127, 8'd128, 8'd255};
		plan[2] = {8'd5, 8'd10, 8'd20, 8'd30};
		plan[3] = {8'd255, 8'd255, 8'd255, 8'd255};
		plan[4] = rand_window();
		plan[5] = {8'd0, 8'd0, 8'd0, 8'd0};
		plan[6] = {8'd30, 8'd10, 8'd5, 8'd40};
		plan[7] = rand_window();
		plan[8] = {8'd1, 8'd1, 8'd2, 8'd2};
		plan[9] = {SHORT_MIN_RST, SHORT_MAX_RST, LONG_MIN_RST, LONG_MAX_RST};

		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// timeout and interval while idle, unused kind
		send_item(KIND_TIMEOUT, 8'h00);
		send_item(KIND_INTERVAL, 8'hff);
		send_item(KIND_UNUSED, 8'h00);
		// below the window, above the window
		send_item(KIND_START, 8'haa);
		send_item(KIND_INTERVAL, 8'h00);
		send_item(KIND_TIMEOUT, 8'h55);
		send_item(KIND_START, 8'h55);
		send_item(KIND_INTERVAL, 8'hff);
		send_item(KIND_TIMEOUT, 8'haa);
		// long after an odd short
		send_item(KIND_START, 8'h0f);
		send_item(KIND_INTERVAL, SHORT_MIN_RST);
		send_item(KIND_INTERVAL, LONG_MAX_RST);
		send_item(KIND_TIMEOUT, 8'hf0);
		// timeout on an incomplete frame
		send_item(KIND_START, 8'h00);
		send_item(KIND_INTERVAL, SHORT_MAX_RST);
		send_item(KIND_INTERVAL, SHORT_MIN_RST);
		send_item(KIND_INTERVAL, LONG_MIN_RST);
		send_item(KIND_TIMEOUT, 8'hff);
		send_item(KIND_START, 8'h00);
		send_item(KIND_TIMEOUT, 8'h00);

		for (ph = 0; ph < 10; ph++) begin
			if (ph > 0) begin
				settle();
				load_window(plan[ph]);
			end
			if (ph == 2)
				long_hold_req = 1'b1;
			run_traffic(ph * PER_PHASE + PER_PHASE / 2);
			if (ph == 4)
				settle();
			run_traffic((ph + 1) * PER_PHASE);
		end

		settle();
		if (sb.mismatches == 0 && sb.pending() == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

endmodule

[sim.f]
hdl/rc5pwd_pkg.sv
hdl/rc5pwd_cfg.sv
hdl/rc5pwd_frame.sv
hdl/rc5_pulse_width_decoder_core.sv
test/rc5_pulse_width_decoder_core_tb.sv
